FILE: sv/srlp_pkg.sv
// ----------------------------------------------------------------------------
// srlp_pkg
// Types, codes and constants shared by the sensor reply line parser modules.
// ----------------------------------------------------------------------------
package srlp_pkg;

  localparam int LINE_MAX_DEF    = 127;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] TEMP_CAP  = 16'h8000;
  localparam logic [15:0] TEMP_PMAX = 16'h7fff;
  localparam logic [15:0] TICK_MAX  = 16'hffff;
  localparam logic [2:0]  LAST_FIELD = 3'd4;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_VT    = 8'h0b;
  localparam logic [7:0] CHR_FF    = 8'h0c;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_COMMA = 8'h2c;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_DOT   = 8'h2e;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic CFG_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_kind_t;

  typedef enum logic [3:0] {
    CL_EOL,
    CL_ZERO,
    CL_COMMA,
    CL_DIGIT,
    CL_SPACE,
    CL_PLUS,
    CL_MINUS,
    CL_DOT,
    CL_OTHER
  } byte_class_t;

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_AFTER = 3'd1,
    PH_WS    = 3'd2,
    PH_INT   = 3'd3,
    PH_FRAC  = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_INVALID = 2'd2,
    ST_PARSE   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_kind_t   kind;
    byte_class_t cls;
    logic [7:0]  data;
    logic [3:0]  digit;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

FILE: sv/srlp_front.sv
// ----------------------------------------------------------------------------
// srlp_front
// Input side: takes words from the stream and classifies them into commands.
// ----------------------------------------------------------------------------
module srlp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // rx_byte
  input  logic [1:0]    s_tuser,   // req_type
  input  logic          q_full,
  output logic          q_push,
  output srlp_pkg::cmd_t q_data
);
  import srlp_pkg::*;

  logic        known;
  cmd_kind_t   kind;
  byte_class_t cls;
  logic        busy;

  always_comb begin
    known = 1'b1;
    kind  = CMD_TICK;
    unique case (s_tuser)
      REQ_START: kind = CMD_START;
      REQ_BYTE:  kind = CMD_BYTE;
      REQ_TICK:  kind = CMD_TICK;
      default:   known = 1'b0;
    endcase
  end

  always_comb begin
    if (s_tdata == CHR_CR || s_tdata == CHR_LF) begin
      cls = CL_EOL;
    end else if (s_tdata == CHR_NUL) begin
      cls = CL_ZERO;
    end else if (s_tdata == CHR_COMMA) begin
      cls = CL_COMMA;
    end else if (s_tdata >= CHR_ZERO && s_tdata <= CHR_NINE) begin
      cls = CL_DIGIT;
    end else if (s_tdata == CHR_SPACE || s_tdata == CHR_TAB || s_tdata == CHR_VT ||
                 s_tdata == CHR_FF) begin
      cls = CL_SPACE;
    end else if (s_tdata == CHR_PLUS) begin
      cls = CL_PLUS;
    end else if (s_tdata == CHR_MINUS) begin
      cls = CL_MINUS;
    end else if (s_tdata == CHR_DOT) begin
      cls = CL_DOT;
    end else begin
      cls = CL_OTHER;
    end
  end

  // hold off the first word until reset has been released
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign s_tready      = !q_full && !busy;
  assign q_push        = s_tvalid && s_tready && known;
  assign q_data.kind   = kind;
  assign q_data.cls    = cls;
  assign q_data.data   = s_tdata;
  assign q_data.digit  = 4'(s_tdata - CHR_ZERO);

endmodule

FILE: sv/srlp_fifo.sv
// ----------------------------------------------------------------------------
// srlp_fifo
// Short command queue between the classifier and the parser core.
// ----------------------------------------------------------------------------
module srlp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/srlp_back.sv
// ----------------------------------------------------------------------------
// srlp_back
// Parser core: runs one queued command a cycle while no result waits; holds the result word.
// ----------------------------------------------------------------------------
module srlp_back #(
  parameter int LINE_MAX = srlp_pkg::LINE_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  srlp_pkg::cmd_t cmd,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic [7:0]     sensor_address,
  input  logic [15:0]    reply_timeout,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [79:0]    m_tdata,   // temperature_centi, vin_one .. vin_four
  output logic [1:0]     m_tuser    // status
);
  import srlp_pkg::*;

  localparam int CC_W = $clog2(LINE_MAX + 1);

  logic            window_open, window_open_next;
  logic [15:0]     elapsed_ticks, elapsed_ticks_next;
  logic [CC_W-1:0] char_count, char_count_next;
  logic [2:0]      field_number, field_number_next;
  phase_t          scan_phase, scan_phase_next;
  logic            minus_seen, minus_seen_next;
  logic [1:0]      decimals_taken, decimals_taken_next;
  logic [15:0]     temp_magnitude, temp_magnitude_next;
  logic [15:0]     value_acc [4];
  logic [15:0]     value_acc_next [4];
  logic            address_bad, address_bad_next;
  logic            text_ended, text_ended_next;

  logic            res_fire;
  status_t         res_status;
  logic            do_end;
  logic            do_parse;
  logic [15:0]     tick_inc;

  phase_t          ph;
  logic            mn;
  logic [1:0]      dc;
  logic            done;
  logic            go_int;
  logic            add_int;
  logic            add_frac;

  logic [1:0]      k;
  logic [18:0]     t_int_sum;
  logic [18:0]     t_frac_sum;
  logic [15:0]     t_capped_int;
  logic [15:0]     t_capped_frac;
  logic [15:0]     t_closed;
  logic [15:0]     t_cap;
  logic [19:0]     v_prod;
  logic [15:0]     v_last;

  assign q_pop = !q_empty && (!m_tvalid || m_tready);
  assign k     = 2'(field_number - 3'd1);

  always_comb begin
    t_int_sum  = {3'b0, temp_magnitude} * 19'd10 + {15'b0, cmd.digit} * 19'd100;
    if (decimals_taken == 2'd0) begin
      t_frac_sum = {3'b0, temp_magnitude} + {15'b0, cmd.digit} * 19'd10;
    end else if (decimals_taken == 2'd1) begin
      t_frac_sum = {3'b0, temp_magnitude} + {15'b0, cmd.digit};
    end else begin
      t_frac_sum = {3'b0, temp_magnitude};
    end
    t_capped_int  = (t_int_sum > {3'b0, TEMP_CAP}) ? TEMP_CAP : t_int_sum[15:0];
    t_capped_frac = (t_frac_sum > {3'b0, TEMP_CAP}) ? TEMP_CAP : t_frac_sum[15:0];
    t_cap = (temp_magnitude > TEMP_CAP) ? TEMP_CAP : temp_magnitude;
    if (minus_seen) begin
      t_closed = 16'(17'h10000 - {1'b0, t_cap});
    end else begin
      t_closed = (t_cap > TEMP_PMAX) ? TEMP_PMAX : t_cap;
    end
    v_prod = {4'b0, value_acc[k]} * 20'd10 + {16'b0, cmd.digit};
    v_last = minus_seen ? 16'(17'h10000 - {1'b0, value_acc[3]}) : value_acc[3];
  end

  always_comb begin
    window_open_next    = window_open;
    elapsed_ticks_next  = elapsed_ticks;
    char_count_next     = char_count;
    field_number_next   = field_number;
    scan_phase_next     = scan_phase;
    minus_seen_next     = minus_seen;
    decimals_taken_next = decimals_taken;
    temp_magnitude_next = temp_magnitude;
    value_acc_next      = value_acc;
    address_bad_next    = address_bad;
    text_ended_next     = text_ended;
    res_fire   = 1'b0;
    res_status = ST_OK;
    do_end     = 1'b0;
    do_parse   = 1'b0;
    tick_inc   = (elapsed_ticks < TICK_MAX) ? elapsed_ticks + 16'd1 : elapsed_ticks;
    ph       = scan_phase;
    mn       = minus_seen;
    dc       = decimals_taken;
    done     = 1'b0;
    go_int   = 1'b0;
    add_int  = 1'b0;
    add_frac = 1'b0;

    if (q_pop) begin
      unique case (cmd.kind)
        CMD_START: begin
          window_open_next    = 1'b1;
          elapsed_ticks_next  = '0;
          char_count_next     = '0;
          field_number_next   = '0;
          scan_phase_next     = PH_ADDR;
          minus_seen_next     = 1'b0;
          decimals_taken_next = '0;
          temp_magnitude_next = '0;
          value_acc_next      = '{default: '0};
          address_bad_next    = 1'b0;
          text_ended_next     = 1'b0;
          if (reply_timeout == '0) begin
            res_fire         = 1'b1;
            res_status       = ST_TIMEOUT;
            window_open_next = 1'b0;
          end
        end
        CMD_TICK: begin
          if (window_open) begin
            elapsed_ticks_next = tick_inc;
            do_end = tick_inc >= reply_timeout;
          end
        end
        CMD_BYTE: begin
          if (window_open) begin
            if (cmd.cls == CL_EOL) begin
              do_end = char_count != '0;
            end else if (char_count >= CC_W'(LINE_MAX)) begin
              res_fire         = 1'b1;
              res_status       = ST_INVALID;
              window_open_next = 1'b0;
            end else begin
              char_count_next = char_count + 1'b1;
              do_parse        = !text_ended;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_parse) begin
      if (scan_phase == PH_ADDR) begin
        address_bad_next = cmd.data != sensor_address;
        scan_phase_next  = PH_AFTER;
        if (cmd.cls == CL_ZERO) begin
          text_ended_next = 1'b1;
        end
      end else if (cmd.cls == CL_ZERO) begin
        text_ended_next = 1'b1;
      end else begin
        if (scan_phase == PH_AFTER) begin
          ph = PH_WS;
          mn = 1'b0;
          dc = '0;
          done = cmd.cls == CL_COMMA;
        end
        if (!done && cmd.cls == CL_COMMA) begin
          done = 1'b1;
          if (field_number < LAST_FIELD) begin
            if (field_number == '0) begin
              temp_magnitude_next = t_closed;
            end else if (minus_seen) begin
              value_acc_next[k] = 16'(17'h10000 - {1'b0, value_acc[k]});
            end
            field_number_next = field_number + 3'd1;
            ph = PH_WS;
            mn = 1'b0;
            dc = '0;
          end else begin
            ph = PH_SKIP;
          end
        end
        if (!done) begin
          if (ph == PH_WS) begin
            if (cmd.cls == CL_PLUS || cmd.cls == CL_MINUS) begin
              mn = cmd.cls == CL_MINUS;
              ph = PH_INT;
            end else if (cmd.cls != CL_SPACE) begin
              go_int = 1'b1;
            end
          end else if (ph == PH_INT) begin
            go_int = 1'b1;
          end else if (ph == PH_FRAC) begin
            if (cmd.cls == CL_DIGIT) begin
              add_frac = 1'b1;
            end else begin
              ph = PH_SKIP;
            end
          end
          if (go_int) begin
            if (cmd.cls == CL_DIGIT) begin
              ph      = PH_INT;
              add_int = 1'b1;
            end else if (cmd.cls == CL_DOT && field_number == '0) begin
              ph = PH_FRAC;
            end else begin
              ph = PH_SKIP;
            end
          end
          if (add_int || add_frac) begin
            if (field_number == '0) begin
              if (add_int) begin
                temp_magnitude_next = t_capped_int;
              end else begin
                temp_magnitude_next = t_capped_frac;
                if (dc < 2'd2) begin
                  dc = dc + 2'd1;
                end
              end
            end else begin
              value_acc_next[k] = v_prod[15:0];
            end
          end
        end
        scan_phase_next     = ph;
        minus_seen_next     = mn;
        decimals_taken_next = dc;
      end
    end

    if (do_end) begin
      res_fire         = 1'b1;
      window_open_next = 1'b0;
      if (char_count == '0) begin
        res_status = ST_TIMEOUT;
      end else if (address_bad) begin
        res_status = ST_INVALID;
      end else if (field_number < LAST_FIELD) begin
        res_status = ST_PARSE;
      end else begin
        res_status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_open    <= 1'b0;
      elapsed_ticks  <= '0;
      char_count     <= '0;
      field_number   <= '0;
      scan_phase     <= PH_ADDR;
      minus_seen     <= 1'b0;
      decimals_taken <= '0;
      temp_magnitude <= '0;
      value_acc      <= '{default: '0};
      address_bad    <= 1'b0;
      text_ended     <= 1'b0;
    end else begin
      window_open    <= window_open_next;
      elapsed_ticks  <= elapsed_ticks_next;
      char_count     <= char_count_next;
      field_number   <= field_number_next;
      scan_phase     <= scan_phase_next;
      minus_seen     <= minus_seen_next;
      decimals_taken <= decimals_taken_next;
      temp_magnitude <= temp_magnitude_next;
      value_acc      <= value_acc_next;
      address_bad    <= address_bad_next;
      text_ended     <= text_ended_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      m_tuser <= res_status;
      if (res_status == ST_OK) begin
        m_tdata <= {v_last, value_acc[2], value_acc[1], value_acc[0], temp_magnitude};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

FILE: sv/sensor_reply_line_parser_unit.sv
// ----------------------------------------------------------------------------
// sensor_reply_line_parser_unit
// Parses a sensor's ASCII reply into status, temperature and four values.
// ----------------------------------------------------------------------------
// One input word is taken every clock cycle while the command queue has room.
// A classifier tags each word and writes it into a QUEUE_DEPTH deep queue; the
// parser core runs one queued word per cycle. The word that ends the reply is
// first written into the queue, and the core's result word is then registered
// in the output register. The core pauses only while a result word sits unread
// in the output register, and the queue absorbs input meanwhile.
// Configuration writes are always taken at once.
module sensor_reply_line_parser_unit #(
  parameter int LINE_MAX    = srlp_pkg::LINE_MAX_DEF,
  parameter int QUEUE_DEPTH = srlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte
  input  logic [1:0]  s_tuser,    // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // temperature_centi, vin_one, vin_two, vin_three, vin_four
  output logic [1:0]  m_tuser,    // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import srlp_pkg::*;

  logic [7:0]  sensor_address;
  logic [15:0] reply_timeout;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  cmd_t        q_in;
  cmd_t        q_head;
  logic [CMD_W-1:0] q_head_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_address <= 8'd65;
      reply_timeout  <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ADDRESS: sensor_address <= cfg_data[7:0];
        CFG_TIMEOUT: reply_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  srlp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  srlp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head_bits),
    .empty     (q_empty)
  );

  assign q_head = cmd_t'(q_head_bits);

  srlp_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .sensor_address (sensor_address),
    .reply_timeout  (reply_timeout),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser)
  );

endmodule
